FILE: hdl/vkdt_pkg.sv
// Shared constants and types for the vertex key dedup table.
package vkdt_pkg;

  // Parameter defaults
  localparam int NUM_KEYS_DEF       = 1024;
  localparam int SLOTS_PER_KEY_DEF  = 8;
  localparam int NORMAL_ID_BITS_DEF = 16;

  // Fixed port field widths
  localparam int KEY_W       = 10;
  localparam int NORMAL_W    = 16;
  localparam int FINAL_W     = 13;
  localparam int COUNT_W     = 14;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  // Outcome of one row lookup
  typedef struct packed {
    logic               alloc;
    logic               overflow;
    logic [FINAL_W-1:0] final_index;
  } res_t;

endpackage

FILE: hdl/vkdt_row_eval.sv
// Row lookup: match the normal in one key row, or pick the next free slot.
module vkdt_row_eval #(
  parameter int SLOTS_PER_KEY  = vkdt_pkg::SLOTS_PER_KEY_DEF,
  parameter int NORMAL_ID_BITS = vkdt_pkg::NORMAL_ID_BITS_DEF,
  parameter int CNT_W          = $clog2(SLOTS_PER_KEY + 1),
  parameter int SLOT_W         = NORMAL_ID_BITS + vkdt_pkg::FINAL_W,
  parameter int ROW_W          = CNT_W + SLOTS_PER_KEY * SLOT_W
) (
  input  logic [ROW_W-1:0]             row,
  input  logic [NORMAL_ID_BITS-1:0]    nid,
  input  logic                         key_ok,
  input  logic [vkdt_pkg::COUNT_W-1:0] next_index,
  output vkdt_pkg::res_t               res,
  output logic [ROW_W-1:0]             row_nxt
);

  logic [CNT_W-1:0]              cnt;
  logic                          hit;
  logic [vkdt_pkg::FINAL_W-1:0]  hit_final;
  logic                          has_free;
  logic                          alloc;
  logic [vkdt_pkg::FINAL_W-1:0]  new_final;
  logic [SLOT_W-1:0]             slot;

  assign cnt       = row[CNT_W-1:0];
  assign has_free  = cnt < CNT_W'(SLOTS_PER_KEY);
  assign new_final = next_index[vkdt_pkg::FINAL_W-1:0];

  // Slots below the fill count are in use; scan downward so the lowest match wins.
  always_comb begin
    hit       = 1'b0;
    hit_final = '0;
    for (int i = SLOTS_PER_KEY - 1; i >= 0; i--) begin
      slot = row[CNT_W + i*SLOT_W +: SLOT_W];
      if ((CNT_W'(i) < cnt) && (slot[NORMAL_ID_BITS-1:0] == nid)) begin
        hit       = 1'b1;
        hit_final = slot[SLOT_W-1:NORMAL_ID_BITS];
      end
    end
  end

  assign alloc = key_ok && !hit && has_free;

  always_comb begin
    res.alloc       = alloc;
    res.overflow    = !key_ok || (!hit && !has_free);
    res.final_index = '0;
    if (key_ok && hit) begin
      res.final_index = hit_final;
    end else if (alloc) begin
      res.final_index = new_final;
    end
  end

  // Fill the first free slot and bump the row's fill count.
  always_comb begin
    row_nxt            = row;
    row_nxt[CNT_W-1:0] = cnt + CNT_W'(1);
    for (int i = 0; i < SLOTS_PER_KEY; i++) begin
      if (CNT_W'(i) == cnt) begin
        row_nxt[CNT_W + i*SLOT_W +: SLOT_W] = {new_final, nid};
      end
    end
  end

endmodule

FILE: hdl/vertex_key_dedup_table.sv
// Top level: vertex index dedup table on a row memory with read-modify-write.
//
//   channel | ports                     | direction | payload
//   --------+---------------------------+-----------+------------------------------------
//   in      | in_tvalid/tready/tdata    | sink      | key_index [9:0], normal_id [25:10]
//   out     | out_tvalid/tready/tdata   | source    | final_index [12:0], is_new, overflow
//
// Per item: the accept edge reads the key's row from the row memory (one read
// port, registered read); the evaluate state then looks it up and writes the row
// back on allocation, so one item is in flight at a time.
// After reset a clearing pass zeroes every row, fill count included, with
// in_tready low. A waiting result does not block acceptance; the evaluate cycle
// holds only while the output register is still full.
module vertex_key_dedup_table #(
  parameter int NUM_KEYS       = vkdt_pkg::NUM_KEYS_DEF,
  parameter int SLOTS_PER_KEY  = vkdt_pkg::SLOTS_PER_KEY_DEF,
  parameter int NORMAL_ID_BITS = vkdt_pkg::NORMAL_ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [vkdt_pkg::IN_TDATA_W-1:0]  in_tdata,   // key_index, normal_id, zero pad
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [vkdt_pkg::OUT_TDATA_W-1:0] out_tdata   // final_index, is_new, overflow, pad
);

  localparam int AW     = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int CNT_W  = $clog2(SLOTS_PER_KEY + 1);
  localparam int SLOT_W = NORMAL_ID_BITS + vkdt_pkg::FINAL_W;
  localparam int ROW_W  = CNT_W + SLOTS_PER_KEY * SLOT_W;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EVAL  = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [AW-1:0]                 clr_addr_r, clr_addr_nxt;
  logic [vkdt_pkg::COUNT_W-1:0]  next_index_r, next_index_nxt;
  logic [AW-1:0]                 key_addr_r;
  logic                          key_ok_r;
  logic [NORMAL_ID_BITS-1:0]     nid_r;
  logic [ROW_W-1:0]              rd_row_r;
  logic                          out_valid_r, out_valid_nxt;
  vkdt_pkg::res_t                out_res_r;

  logic [ROW_W-1:0]              mem [NUM_KEYS];

  logic                          in_fire;
  logic                          go;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [ROW_W-1:0]              mem_wdata;
  logic [31:0]                   key_ext;
  logic [31:0]                   nid_ext;
  logic [AW-1:0]                 in_addr;
  logic                          in_key_ok;
  vkdt_pkg::res_t                res;
  logic [ROW_W-1:0]              row_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign go        = (state_r == S_EVAL) && (!out_valid_r || out_tready);

  assign key_ext   = 32'(in_tdata[vkdt_pkg::KEY_W-1:0]);
  assign nid_ext   = 32'(in_tdata[vkdt_pkg::KEY_W +: vkdt_pkg::NORMAL_W]);
  assign in_addr   = key_ext[AW-1:0];
  assign in_key_ok = key_ext < 32'(NUM_KEYS);

  vkdt_row_eval #(
    .SLOTS_PER_KEY  (SLOTS_PER_KEY),
    .NORMAL_ID_BITS (NORMAL_ID_BITS),
    .CNT_W          (CNT_W),
    .SLOT_W         (SLOT_W),
    .ROW_W          (ROW_W)
  ) u_row_eval (
    .row        (rd_row_r),
    .nid        (nid_r),
    .key_ok     (key_ok_r),
    .next_index (next_index_r),
    .res        (res),
    .row_nxt    (row_nxt)
  );

  // Memory write: zero rows during the clear pass, write back on allocation.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = key_addr_r;
    mem_wdata = row_nxt;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else if (go && res.alloc) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_row_r <= mem[in_addr];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    next_index_nxt = next_index_r;
    out_valid_nxt  = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(NUM_KEYS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        if (go) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          if (res.alloc) begin
            next_index_nxt = next_index_r + vkdt_pkg::COUNT_W'(1);
          end
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_addr_r   <= '0;
      next_index_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      next_index_r <= next_index_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Hold the item's key and normal for the evaluate cycle; latch the result.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      key_addr_r <= in_addr;
      key_ok_r   <= in_key_ok;
      nid_r      <= nid_ext[NORMAL_ID_BITS-1:0];
    end
    if (go) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = vkdt_pkg::OUT_TDATA_W'({out_res_r.overflow, out_res_r.alloc,
                                              out_res_r.final_index});

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !in_tready)
    else $error("item accepted during clear pass");

  a_count_on_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (go && res.alloc) |=> (next_index_r == $past(next_index_r) + vkdt_pkg::COUNT_W'(1)))
    else $error("allocation did not advance the index counter");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(go && res.alloc) |=> (next_index_r == $past(next_index_r)))
    else $error("index counter moved without allocation");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_res_r.alloc && out_res_r.overflow))
    else $error("result both new and overflow");

  a_overflow_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_res_r.overflow) |-> (out_res_r.final_index == '0))
    else $error("overflow result carries a nonzero index");

endmodule

FILE: tb/vertex_key_dedup_table_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the vertex key dedup table: corner stimulus, index prediction.
module vertex_key_dedup_table_test;

  localparam int NUM_KEYS      = vkdt_pkg::NUM_KEYS_DEF;
  localparam int SLOTS_PER_KEY = vkdt_pkg::SLOTS_PER_KEY_DEF;
  localparam int KEY_W         = vkdt_pkg::KEY_W;
  localparam int NORMAL_W      = vkdt_pkg::NORMAL_W;
  localparam int FINAL_W       = vkdt_pkg::FINAL_W;
  localparam int COUNT_W       = vkdt_pkg::COUNT_W;
  localparam int IN_TDATA_W    = vkdt_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W   = vkdt_pkg::OUT_TDATA_W;
  localparam int ROW_CELLS     = NUM_KEYS * SLOTS_PER_KEY;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // key_index, normal_id, zero pad
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // final_index, is_new, overflow, pad

  // Shadow copy of the slot table
  logic [NORMAL_W-1:0] row_normal [ROW_CELLS];
  logic [FINAL_W-1:0]  row_final  [ROW_CELLS];
  bit                  row_used   [ROW_CELLS];
  logic [COUNT_W-1:0]  alloc_count = '0;

  vkdt_pkg::res_t pending_results [$];

  int  err_count = 0;
  int  corners_sent = 0;
  int  results_seen = 0;
  int  allocs_predicted = 0;
  int  hits_predicted = 0;
  int  overflows_predicted = 0;
  int  cycle_count = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  ready_phase = 0;

  vertex_key_dedup_table i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < ROW_CELLS; i++) begin
      row_used[i] = 1'b0;
    end
  end

  // Look up the pair in its row; allocate the first free slot on a miss.
  function automatic vkdt_pkg::res_t resolve_corner(logic [KEY_W-1:0] key,
                                                    logic [NORMAL_W-1:0] nid);
    vkdt_pkg::res_t r;
    int   base;
    int   free_slot;
    bit   found;
    r = '0;
    free_slot = -1;
    found = 1'b0;
    base = int'(key) * SLOTS_PER_KEY;
    if (int'(key) >= NUM_KEYS) begin
      r.overflow = 1'b1;
      return r;
    end
    for (int s = 0; s < SLOTS_PER_KEY; s++) begin
      if (row_used[base + s]) begin
        if (!found && row_normal[base + s] == nid) begin
          found = 1'b1;
          r.final_index = row_final[base + s];
        end
      end else if (free_slot < 0) begin
        free_slot = base + s;
      end
    end
    if (found) begin
      hits_predicted++;
      return r;
    end
    if (free_slot < 0) begin
      overflows_predicted++;
      r.overflow = 1'b1;
      return r;
    end
    row_normal[free_slot] = nid;
    row_final[free_slot]  = alloc_count[FINAL_W-1:0];
    row_used[free_slot]   = 1'b1;
    r.alloc       = 1'b1;
    r.final_index = alloc_count[FINAL_W-1:0];
    alloc_count   = alloc_count + 1'b1;
    allocs_predicted++;
    return r;
  endfunction

  // Offer one item and hold it until accepted; valid stays high afterwards.
  task automatic send_corner(input logic [KEY_W-1:0] key, input logic [NORMAL_W-1:0] nid);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-KEY_W-NORMAL_W){1'b0}}, nid, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(resolve_corner(key, nid));
    corners_sent++;
  endtask

  task automatic idle_sender(input int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(input string field, input int want, input int got);
    err_count++;
    if (err_count <= MAX_REPORTS) begin
      $display("mismatch on result %0d: %s expected %0d, got %0d",
               results_seen, field, want, got);
    end
  endtask

  // Receiver: a long hold on request, else a stall pattern rotating through four modes.
  always @(posedge clk) begin
    ready_phase++;
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      case ((ready_phase >> 7) % 4)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (ready_phase % 4 == 0);
        default: out_tready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    vkdt_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, final_index", -1, int'(out_tdata[FINAL_W-1:0]));
      end else begin
        want = pending_results.pop_front();
        if (out_tdata[FINAL_W-1:0] !== want.final_index)
          report_mismatch("final_index", int'(want.final_index), int'(out_tdata[FINAL_W-1:0]));
        if (out_tdata[FINAL_W] !== want.alloc)
          report_mismatch("is_new", int'(want.alloc), int'(out_tdata[FINAL_W]));
        if (out_tdata[FINAL_W+1] !== want.overflow)
          report_mismatch("overflow", int'(want.overflow), int'(out_tdata[FINAL_W+1]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Field extremes, bit toggles, first allocation and a repeat hit.
  task automatic test_corner_extremes();
    send_corner(10'd0, 16'h0000);
    send_corner(10'd0, 16'h0000);
    send_corner(10'd1023, 16'hFFFF);
    send_corner(10'd1023, 16'hFFFF);
    send_corner(10'd1023, 16'h0000);
    send_corner(10'd0, 16'hFFFF);
    send_corner(10'h2AA, 16'h5555);
    send_corner(10'h155, 16'hAAAA);
  endtask

  // Fill one row, overflow it, then hit inside the full row.
  task automatic test_row_full();
    for (int n = 0; n < SLOTS_PER_KEY; n++) begin
      send_corner(10'd5, 16'(10 + n));
    end
    send_corner(10'd5, 16'd99);
    send_corner(10'd5, 16'd13);
    send_corner(10'd5, 16'(10 + SLOTS_PER_KEY - 1));
  endtask

  // Hold the receiver off while items keep coming, then drain completely.
  task automatic test_output_stall();
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++) begin
      send_corner(KEY_W'($urandom_range(0, 7) + 40), NORMAL_W'($urandom_range(0, 9)));
    end
    wait_drained();
  endtask

  task automatic test_random_corners(input int count);
    int burst;
    int sent;
    bit quiet;
    int pick;
    logic [KEY_W-1:0]    key;
    logic [NORMAL_W-1:0] nid;
    sent = 0;
    while (sent < count) begin
      quiet = ((sent / 100) % 3 == 2);
      burst = $urandom_range(1, 16);
      for (int b = 0; b < burst && sent < count; b++) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          // hot rows with few normals: they fill, overflow and hit often
          key = {5'($urandom_range(0, 31)), 5'b10011};
          nid = NORMAL_W'($urandom_range(0, 11));
        end else if (pick < 85) begin
          key = KEY_W'($urandom_range(0, 63));
          nid = NORMAL_W'($urandom_range(0, 3)) << $urandom_range(0, 14);
        end else begin
          key = KEY_W'($urandom_range(0, NUM_KEYS - 1));
          nid = NORMAL_W'($urandom);
        end
        send_corner(key, nid);
        sent++;
      end
      idle_sender(quiet ? 0 : $urandom_range(0, 6));
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_corner_extremes();
    test_row_full();
    idle_sender(3);
    test_output_stall();
    test_random_corners(700);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("covered %0d corners: %0d allocations, %0d repeat hits, %0d full-row overflows",
             corners_sent, allocs_predicted, hits_predicted, overflows_predicted);
    $display("checked %0d results incl. a %0d-cycle output hold and a full drain",
             results_seen, HOLD_CYCLES);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
